### sv/u8sd_pkg.sv
// Package with the status codes and byte-class constants for the UTF-8 stream decoder.
package u8sd_pkg;

	// Result status codes.
	localparam logic [2:0] ST_PENDING  = 3'd0;
	localparam logic [2:0] ST_COMPLETE = 3'd1;
	localparam logic [2:0] ST_BAD_LEAD = 3'd2;
	localparam logic [2:0] ST_NO_CONT  = 3'd3;
	localparam logic [2:0] ST_TRUNC    = 3'd4;

	// Field widths.
	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 21;
	localparam int unsigned StW   = 3;

	// Byte classes and payload masks.
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] LEAD2_TAG = 8'hC0;
	localparam logic [7:0] LEAD2_MSK = 8'hE0;
	localparam logic [7:0] LEAD3_TAG = 8'hE0;
	localparam logic [7:0] LEAD3_MSK = 8'hF0;
	localparam logic [7:0] LEAD4_TAG = 8'hF0;
	localparam logic [7:0] LEAD4_MSK = 8'hF8;
	localparam logic [7:0] PAY1_MSK  = 8'h7F;
	localparam logic [7:0] PAY2_MSK  = 8'h1F;
	localparam logic [7:0] PAY3_MSK  = 8'h0F;
	localparam logic [7:0] PAY4_MSK  = 8'h07;
	localparam logic [7:0] CONT_PAY  = 8'h3F;

	// Lead byte decode: remaining continuation count and masked payload.
	typedef struct packed {
		logic       valid;
		logic       single;
		logic [1:0] more;
		logic [7:0] payload;
	} lead_info_t;

endpackage

### sv/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: input register, decode logic and result register.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | data_byte[7:0], end_of_buffer
//  out     | out_valid / out_ready | code_point[20:0], status[2:0], buffer_ok
//
// One byte is accepted per cycle unless the output stalls; it is decoded into the result register.
// The rate is set by the decode step between the input register and the result register,
// which also updates the sequence state in that same cycle.
// Reset clears the pipeline valids and the sequence state (count, partial code, error flag).
// A stall on the output holds the result register and the input register, and in_ready
// then drops once both are full.
module utf8_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic [2:0]  status,
	output logic        buffer_ok
);

	// Input register.
	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Sequence state.
	logic [1:0]  left_q;
	logic [20:0] part_q;
	logic        err_q;

	// Result register.
	logic        vld_s2;
	logic [20:0] cp_s2;
	logic [2:0]  st_s2;
	logic        ok_s2;

	logic                 adv;
	u8sd_pkg::lead_info_t lead;
	logic                 is_cont;
	logic [1:0]           left_d;
	logic [20:0]          part_d;
	logic                 err_d;
	logic [20:0]          cp_d;
	logic [2:0]           st_d;
	logic                 ok_d;

	// Pipeline flow control.
	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_buffer;
		end
	end

	// Lead byte classification.
	always_comb begin
		lead = '{valid: 1'b0, single: 1'b0, more: 2'd0, payload: 8'd0};
		priority if (!byte_s1[7]) begin
			lead = '{valid: 1'b1, single: 1'b1, more: 2'd0,
				payload: byte_s1 & u8sd_pkg::PAY1_MSK};
		end else if ((byte_s1 & u8sd_pkg::LEAD2_MSK) == u8sd_pkg::LEAD2_TAG) begin
			lead = '{valid: 1'b1, single: 1'b0, more: 2'd1,
				payload: byte_s1 & u8sd_pkg::PAY2_MSK};
		end else if ((byte_s1 & u8sd_pkg::LEAD3_MSK) == u8sd_pkg::LEAD3_TAG) begin
			lead = '{valid: 1'b1, single: 1'b0, more: 2'd2,
				payload: byte_s1 & u8sd_pkg::PAY3_MSK};
		end else if ((byte_s1 & u8sd_pkg::LEAD4_MSK) == u8sd_pkg::LEAD4_TAG) begin
			lead = '{valid: 1'b1, single: 1'b0, more: 2'd3,
				payload: byte_s1 & u8sd_pkg::PAY4_MSK};
		end else begin
			lead = '{valid: 1'b0, single: 1'b0, more: 2'd0, payload: 8'd0};
		end
	end

	assign is_cont = (byte_s1 & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG;

	// Next state and result for the byte in the input register.
	always_comb begin
		left_d = left_q;
		part_d = part_q;
		err_d  = err_q;
		cp_d   = '0;
		st_d   = u8sd_pkg::ST_PENDING;
		ok_d   = 1'b0;
		priority if (left_q == 2'd0) begin
			priority if (!lead.valid) begin
				st_d  = u8sd_pkg::ST_BAD_LEAD;
				err_d = 1'b1;
			end else if (lead.single) begin
				st_d = u8sd_pkg::ST_COMPLETE;
				cp_d = {13'd0, lead.payload};
			end else begin
				part_d = {13'd0, lead.payload};
				left_d = lead.more;
			end
		end else if (is_cont) begin
			left_d = left_q - 2'd1;
			if (left_q == 2'd1) begin
				st_d   = u8sd_pkg::ST_COMPLETE;
				cp_d   = {part_q[14:0], byte_s1[5:0]};
				part_d = '0;
			end else begin
				part_d = {part_q[14:0], byte_s1[5:0]};
			end
		end else begin
			st_d   = u8sd_pkg::ST_NO_CONT;
			err_d  = 1'b1;
			left_d = 2'd0;
			part_d = '0;
		end

		// End of buffer: flag truncation, report validity, clear the state.
		if (last_s1) begin
			if (st_d == u8sd_pkg::ST_PENDING && left_d != 2'd0) begin
				st_d  = u8sd_pkg::ST_TRUNC;
				err_d = 1'b1;
			end
			ok_d   = !err_d;
			left_d = 2'd0;
			part_d = '0;
			err_d  = 1'b0;
		end
	end

	// Sequence state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
			part_q <= '0;
			err_q  <= 1'b0;
		end else if (adv) begin
			left_q <= left_d;
			part_q <= part_d;
			err_q  <= err_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || out_ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cp_s2 <= cp_d;
			st_s2 <= st_d;
			ok_s2 <= ok_d;
		end
	end

	assign out_valid  = vld_s2;
	assign code_point = cp_s2;
	assign status     = st_s2;
	assign buffer_ok  = ok_s2;

	// An idle decoder holds no partial code point.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		left_q == 2'd0 |-> part_q == 21'd0)
		else $error("partial code point left over while idle");

	// A beat ending the buffer leaves the state cleared.
	a_eob_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> left_q == 2'd0 && !err_q)
		else $error("state not cleared after end of buffer");

	// A valid buffer can only end on a completed code point.
	a_ok_complete: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && ok_s2 |-> st_s2 == u8sd_pkg::ST_COMPLETE)
		else $error("buffer_ok with a non-complete status");

	// The code point is zero unless a code point completed.
	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && st_s2 != u8sd_pkg::ST_COMPLETE |-> cp_s2 == 21'd0)
		else $error("code point nonzero without completion");

endmodule

### dv/u8sd_result_checker.sv
// Checker for the UTF-8 stream decoder: predicts each result from the accepted bytes and compares.
module u8sd_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [20:0] code_point,
	input  logic [2:0]  status,
	input  logic        buffer_ok,
	output int          mismatch_count,
	output int          pending_results
);

	typedef struct packed {
		logic [u8sd_pkg::CpW-1:0] cp;
		logic [u8sd_pkg::StW-1:0] st;
		logic                     ok;
	} decode_result_t;

	// Decoder state as the predictor sees it.
	logic [1:0]               seq_left;
	logic [u8sd_pkg::CpW-1:0] seq_code;
	logic                     buf_err;

	decode_result_t expected_results[$];

	// Works out the result of one accepted byte and updates the sequence state.
	task automatic predict_byte(input logic [7:0] b, input logic last);
		decode_result_t r;
		r.cp = '0;
		r.st = u8sd_pkg::ST_PENDING;
		r.ok = 1'b0;
		if (seq_left == 2'd0) begin
			if (b[7] == 1'b0) begin
				r.st = u8sd_pkg::ST_COMPLETE;
				r.cp = u8sd_pkg::CpW'(b & u8sd_pkg::PAY1_MSK);
			end else if ((b & u8sd_pkg::LEAD2_MSK) == u8sd_pkg::LEAD2_TAG) begin
				seq_code = u8sd_pkg::CpW'(b & u8sd_pkg::PAY2_MSK);
				seq_left = 2'd1;
			end else if ((b & u8sd_pkg::LEAD3_MSK) == u8sd_pkg::LEAD3_TAG) begin
				seq_code = u8sd_pkg::CpW'(b & u8sd_pkg::PAY3_MSK);
				seq_left = 2'd2;
			end else if ((b & u8sd_pkg::LEAD4_MSK) == u8sd_pkg::LEAD4_TAG) begin
				seq_code = u8sd_pkg::CpW'(b & u8sd_pkg::PAY4_MSK);
				seq_left = 2'd3;
			end else begin
				// Stray continuation byte or a byte that can never lead.
				r.st = u8sd_pkg::ST_BAD_LEAD;
				buf_err = 1'b1;
			end
		end else if ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG) begin
			seq_code = {seq_code[u8sd_pkg::CpW-7:0], b[5:0]};
			seq_left = seq_left - 2'd1;
			if (seq_left == 2'd0) begin
				r.st = u8sd_pkg::ST_COMPLETE;
				r.cp = seq_code;
				seq_code = '0;
			end
		end else begin
			// The sequence is broken; the byte is dropped, not taken as a new lead.
			r.st = u8sd_pkg::ST_NO_CONT;
			buf_err = 1'b1;
			seq_left = 2'd0;
			seq_code = '0;
		end

		// The last byte of a buffer reports on the whole buffer and clears everything.
		if (last) begin
			if (r.st == u8sd_pkg::ST_PENDING && seq_left != 2'd0) begin
				r.st = u8sd_pkg::ST_TRUNC;
				buf_err = 1'b1;
			end
			r.ok = ~buf_err;
			seq_left = 2'd0;
			seq_code = '0;
			buf_err = 1'b0;
		end
		expected_results.push_back(r);
	endtask

	// Compare each result beat with the oldest prediction, then predict the new byte.
	always @(posedge clk or negedge arst_n) begin
		decode_result_t exp_r;
		if (!arst_n) begin
			seq_left = 2'd0;
			seq_code = '0;
			buf_err = 1'b0;
			expected_results.delete();
			mismatch_count = 0;
			pending_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected: cp %h status %0d ok %0b",
						$time, code_point, status, buffer_ok);
					mismatch_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (code_point !== exp_r.cp) begin
						$display("%0t: code_point expected %h actual %h",
							$time, exp_r.cp, code_point);
						mismatch_count++;
					end
					if (status !== exp_r.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.st, status);
						mismatch_count++;
					end
					if (buffer_ok !== exp_r.ok) begin
						$display("%0t: buffer_ok expected %0b actual %0b",
							$time, exp_r.ok, buffer_ok);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_byte(data_byte, end_of_buffer);
			end
			pending_results = expected_results.size();
		end
	end

endmodule

### dv/tb_top.sv
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus, ready stalls and verdict.
module tb_top;

	localparam int RandomBytes  = 1700;
	localparam int QuietFrom    = 1400;
	localparam int PauseAt      = 800;
	localparam int StallLimit   = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        end_of_buffer;
	logic        out_valid;
	logic        out_ready;
	logic [20:0] code_point;
	logic [2:0]  status;
	logic        buffer_ok;

	int          mismatch_count;
	int          pending_results;
	int          bytes_sent;
	int          idle_cycles;
	bit          idling_on;
	bit          paused_once;
	logic [7:0]  buffer_bytes[$];

	utf8_stream_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.code_point    (code_point),
		.status        (status),
		.buffer_ok     (buffer_ok)
	);

	u8sd_result_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.end_of_buffer   (end_of_buffer),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.code_point      (code_point),
		.status          (status),
		.buffer_ok       (buffer_ok),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// Free-running clock, period 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: ends the run when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Sends one byte, with an optional gap before it, and waits for the beat.
	task automatic send_byte(input logic [7:0] b, input logic eob, input bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	// Holds the sender off until every predicted result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	// Lead byte for a sequence of n bytes with random payload bits.
	function automatic logic [7:0] lead_byte(input int n);
		unique case (n)
			1: lead_byte = 8'($urandom_range(0, 127));
			2: lead_byte = u8sd_pkg::LEAD2_TAG | 8'($urandom_range(0, 31));
			3: lead_byte = u8sd_pkg::LEAD3_TAG | 8'($urandom_range(0, 15));
			default: lead_byte = u8sd_pkg::LEAD4_TAG | 8'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		cont_byte = u8sd_pkg::CONT_TAG | 8'($urandom_range(0, 63));
	endfunction

	// Appends one character to the buffer: mostly well formed, some noise and broken ones.
	task automatic append_char();
		int pick;
		int n;
		int k;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 78) begin
			n = $urandom_range(1, 4);
			buffer_bytes.push_back(lead_byte(n));
			for (k = 1; k < n; k++) buffer_bytes.push_back(cont_byte());
		end else if (pick < 90) begin
			buffer_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			// Lead byte, too few continuations, then a byte that is not one.
			n = $urandom_range(2, 4);
			buffer_bytes.push_back(lead_byte(n));
			for (k = $urandom_range(0, n - 2); k > 0; k--) buffer_bytes.push_back(cont_byte());
			b = 8'($urandom_range(0, 255));
			if ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG) b = b ^ 8'h40;
			buffer_bytes.push_back(b);
		end
	endtask

	// Builds one random buffer, sometimes cut off in the middle of its last character.
	task automatic send_random_buffer();
		int n;
		int k;
		bit gaps;
		buffer_bytes.delete();
		for (k = $urandom_range(1, 6); k > 0; k--) append_char();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(2, 4);
			buffer_bytes.push_back(lead_byte(n));
			for (k = $urandom_range(0, n - 2); k > 0; k--) buffer_bytes.push_back(cont_byte());
		end
		gaps = idling_on && $urandom_range(0, 2) != 0;
		for (k = 0; k < buffer_bytes.size(); k++) begin
			send_byte(buffer_bytes[k], k == buffer_bytes.size() - 1, gaps);
		end
	endtask

	// Result side: ready stalls in bursts while idling is on, then steady.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (idling_on && $urandom_range(0, 1) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// Byte side: reset, directed bytes, random buffers, drain and verdict.
	initial begin
		in_valid = 1'b0;
		data_byte = 8'h00;
		end_of_buffer = 1'b0;
		arst_n = 1'b0;
		idle_cycles = 0;
		bytes_sent = 0;
		idling_on = 1'b1;
		paused_once = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ASCII extremes, a two-byte character and the largest two-, three- and four-byte forms.
		send_byte(8'h00, 1'b0, idling_on);
		send_byte(8'h7F, 1'b0, idling_on);
		send_byte(8'hC2, 1'b0, idling_on);
		send_byte(8'hA9, 1'b0, idling_on);
		send_byte(8'hDF, 1'b0, idling_on);
		send_byte(8'hBF, 1'b0, idling_on);
		send_byte(8'hEF, 1'b0, idling_on);
		send_byte(8'hBF, 1'b0, idling_on);
		send_byte(8'hBF, 1'b0, idling_on);
		send_byte(8'hF7, 1'b0, idling_on);
		send_byte(8'hBF, 1'b0, idling_on);
		send_byte(8'hBF, 1'b0, idling_on);
		send_byte(8'hBF, 1'b1, idling_on);
		// Bad leads: stray continuation and bytes that can never lead.
		send_byte(8'h80, 1'b0, idling_on);
		send_byte(8'hFF, 1'b0, idling_on);
		send_byte(8'hF8, 1'b0, idling_on);
		// Missing continuation by a plain byte, then truncation at end of buffer.
		send_byte(8'hE2, 1'b0, idling_on);
		send_byte(8'h41, 1'b0, idling_on);
		send_byte(8'hE2, 1'b0, idling_on);
		send_byte(8'h82, 1'b1, idling_on);
		// A clean one-byte buffer after the error was cleared.
		send_byte(8'h41, 1'b1, idling_on);
		// A lead where a continuation belongs, on the last byte.
		send_byte(8'hC3, 1'b0, idling_on);
		send_byte(8'hC3, 1'b1, idling_on);
		// A bad lead on the last byte.
		send_byte(8'hBF, 1'b1, idling_on);
		wait_drained();

		bytes_sent = 0;
		while (bytes_sent < RandomBytes) begin
			if (bytes_sent >= QuietFrom) idling_on = 1'b0;
			if (!paused_once && bytes_sent >= PauseAt) begin
				paused_once = 1'b1;
				wait_drained();
			end
			send_random_buffer();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
